>>> design/segy_pkg.sv
// ----------------------------------------------------------------------------
// segy_pkg
// Shared types and codes for the SEG-Y trace picker: the sample request
// handed from the parser to the float converter, the configuration register
// indexes and the binary header format codes.
// ----------------------------------------------------------------------------
package segy_pkg;

  localparam int unsigned IDX_W  = 15;
  localparam int unsigned TIME_W = 21;
  localparam int unsigned WORD_W = 32;

  localparam logic CFG_TGT_XLINE  = 1'b0;
  localparam logic CFG_TGT_INLINE = 1'b1;

  localparam logic [15:0] FMT_CODE_IBM  = 16'd1;
  localparam logic [15:0] FMT_CODE_INT4 = 16'd2;
  localparam logic [15:0] FMT_CODE_INT2 = 16'd3;
  localparam logic [15:0] FMT_CODE_FIX4 = 16'd4;
  localparam logic [15:0] FMT_CODE_IEEE = 16'd5;

  typedef struct packed {
    logic [IDX_W-1:0]  sample_index;
    logic [TIME_W-1:0] time_ms;
    logic [WORD_W-1:0] raw_word;
    logic              last;
    logic              status;
    logic              is_ibm;
  } req_t;

endpackage

>>> design/segy_parse.sv
// ----------------------------------------------------------------------------
// segy_parse
// Byte-serial SEG-Y parser: header skip, binary header decode, trace header
// match and sample assembly. Emits one registered request per target sample.
// ----------------------------------------------------------------------------
module segy_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_sof,
  input  logic [31:0]       tgt_xline,
  input  logic [31:0]       tgt_inline,
  output logic              req_valid,
  input  logic              req_ready,
  output segy_pkg::req_t    req
);

  typedef enum logic [4:0] {
    PH_TEXT = 5'b00001,
    PH_BIN  = 5'b00010,
    PH_THDR = 5'b00100,
    PH_SAMP = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    FC_IBM  = 3'd0,
    FC_IEEE = 3'd1,
    FC_BAD4 = 3'd2,
    FC_BAD2 = 3'd3,
    FC_BAD0 = 3'd4
  } fmt_t;

  localparam logic [11:0] TEXT_LAST = 12'd3199;
  localparam logic [11:0] BIN_LAST  = 12'd399;
  localparam logic [11:0] THDR_LAST = 12'd239;
  localparam logic [11:0] OFF_DT_LO = 12'd16;
  localparam logic [11:0] OFF_DT_HI = 12'd17;
  localparam logic [11:0] OFF_NS_LO = 12'd20;
  localparam logic [11:0] OFF_NS_HI = 12'd21;
  localparam logic [11:0] OFF_FM_LO = 12'd24;
  localparam logic [11:0] OFF_FM_HI = 12'd25;
  localparam logic [11:0] OFF_XL_LO = 12'd8;
  localparam logic [11:0] OFF_XL_HI = 12'd11;
  localparam logic [11:0] OFF_IL_LO = 12'd12;
  localparam logic [11:0] OFF_IL_HI = 12'd15;
  // floor(x/1000) = (x * 33555) >> 25, exact for x <= 32768
  localparam logic [15:0] DIV_MUL   = 16'd33555;

  phase_t         phase_r, phase_nxt;
  logic [11:0]    cnt_r, cnt_nxt;
  logic           big_r, big_nxt;
  logic [15:0]    spt_r, spt_nxt;
  logic [6:0]     ivl_r, ivl_nxt;
  fmt_t           fmt_r, fmt_nxt;
  logic [31:0]    asm_r, asm_nxt;
  logic [31:0]    xl_r, xl_nxt;
  logic [31:0]    il_r, il_nxt;
  logic [15:0]    scnt_r, scnt_nxt;
  logic [20:0]    time_r, time_nxt;
  logic           match_r, match_nxt;
  logic           v_r, v_nxt;
  segy_pkg::req_t req_r, req_nxt;

  logic           in_acc;
  logic           emit;
  phase_t         ph_cur;
  logic [11:0]    off;
  logic           match_now;
  logic [2:0]     bps;

  // binary header decode terms
  logic [15:0]    raw_le;
  logic           dec_big;
  logic [15:0]    dec_fmt;
  logic [15:0]    dec_dt;
  logic [15:0]    dec_ns;
  logic [15:0]    dt_mag;
  logic [31:0]    dt_prod;
  logic [6:0]     dt_q;
  logic [6:0]     dec_ivl;
  fmt_t           dec_fc;

  assign in_ready  = !v_r || req_ready;
  assign in_acc    = in_valid && in_ready;
  assign req_valid = v_r;
  assign req       = req_r;

  assign raw_le  = {in_byte, asm_r[23:16]};
  assign dec_big = !(($signed(raw_le) >= 16'sd1) && ($signed(raw_le) <= 16'sd5));
  assign dec_fmt = dec_big ? {asm_r[23:16], in_byte} : raw_le;
  assign dec_dt  = dec_big ? {asm_r[7:0], asm_r[15:8]} : asm_r[15:0];
  assign dec_ns  = dec_big ? {spt_r[7:0], spt_r[15:8]} : spt_r;
  assign dt_mag  = dec_dt[15] ? (16'd0 - dec_dt) : dec_dt;
  assign dt_prod = dt_mag * DIV_MUL;
  assign dt_q    = {1'b0, dt_prod[30:25]};
  assign dec_ivl = dec_dt[15] ? (7'd0 - dt_q) : dt_q;

  always_comb begin
    case (dec_fmt)
      segy_pkg::FMT_CODE_IBM:  dec_fc = FC_IBM;
      segy_pkg::FMT_CODE_IEEE: dec_fc = FC_IEEE;
      segy_pkg::FMT_CODE_INT4,
      segy_pkg::FMT_CODE_FIX4: dec_fc = FC_BAD4;
      segy_pkg::FMT_CODE_INT2: dec_fc = FC_BAD2;
      default:                 dec_fc = FC_BAD0;
    endcase
  end

  always_comb begin
    case (fmt_r)
      FC_BAD2: bps = 3'd2;
      FC_BAD0: bps = 3'd0;
      default: bps = 3'd4;
    endcase
  end

  assign ph_cur    = in_sof ? PH_TEXT : phase_r;
  assign off       = in_sof ? 12'd0 : cnt_r;
  assign match_now = (xl_r == tgt_xline) && (il_r == tgt_inline);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    big_nxt   = big_r;
    spt_nxt   = spt_r;
    ivl_nxt   = ivl_r;
    fmt_nxt   = fmt_r;
    asm_nxt   = asm_r;
    xl_nxt    = xl_r;
    il_nxt    = il_r;
    scnt_nxt  = scnt_r;
    time_nxt  = time_r;
    match_nxt = match_r;
    emit      = 1'b0;
    req_nxt   = req_r;
    if (in_acc) begin
      if (in_sof) begin
        phase_nxt = PH_TEXT;
        cnt_nxt   = 12'd0;
      end
      unique case (ph_cur)
        PH_TEXT: begin
          if (off >= TEXT_LAST) begin
            phase_nxt = PH_BIN;
            cnt_nxt   = 12'd0;
          end else begin
            cnt_nxt = off + 12'd1;
          end
        end
        PH_BIN: begin
          case (off)
            OFF_DT_LO: asm_nxt[7:0]   = in_byte;
            OFF_DT_HI: asm_nxt[15:8]  = in_byte;
            OFF_NS_LO: spt_nxt[7:0]   = in_byte;
            OFF_NS_HI: spt_nxt[15:8]  = in_byte;
            OFF_FM_LO: asm_nxt[23:16] = in_byte;
            OFF_FM_HI: begin
              big_nxt = dec_big;
              ivl_nxt = dec_ivl;
              spt_nxt = dec_ns[15] ? 16'd0 : dec_ns;
              fmt_nxt = dec_fc;
            end
            default: ;
          endcase
          if (off >= BIN_LAST) begin
            phase_nxt = PH_THDR;
            cnt_nxt   = 12'd0;
          end else begin
            cnt_nxt = off + 12'd1;
          end
        end
        PH_THDR: begin
          if (off >= OFF_XL_LO && off <= OFF_XL_HI) begin
            xl_nxt = big_r ? {xl_r[23:0], in_byte} : {in_byte, xl_r[31:8]};
          end else if (off >= OFF_IL_LO && off <= OFF_IL_HI) begin
            il_nxt = big_r ? {il_r[23:0], in_byte} : {in_byte, il_r[31:8]};
          end
          if (off < THDR_LAST) begin
            cnt_nxt = off + 12'd1;
          end else begin
            cnt_nxt   = 12'd0;
            scnt_nxt  = 16'd0;
            time_nxt  = 21'd0;
            match_nxt = match_now;
            if (match_now && spt_r != 16'd0 && fmt_r != FC_IBM && fmt_r != FC_IEEE) begin
              emit                 = 1'b1;
              req_nxt.sample_index = '0;
              req_nxt.time_ms      = '0;
              req_nxt.raw_word     = '0;
              req_nxt.last         = 1'b1;
              req_nxt.status       = 1'b1;
              req_nxt.is_ibm       = 1'b0;
              phase_nxt            = PH_DONE;
            end else if (spt_r == 16'd0 || bps == 3'd0) begin
              if (match_now) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = PH_SAMP;
            end
          end
        end
        PH_SAMP: begin
          asm_nxt = big_r ? {asm_r[23:0], in_byte} : {in_byte, asm_r[31:8]};
          if ((off + 12'd1) < {9'd0, bps}) begin
            cnt_nxt = off + 12'd1;
          end else begin
            cnt_nxt = 12'd0;
            if (match_r) begin
              emit                 = 1'b1;
              req_nxt.sample_index = scnt_r[14:0];
              req_nxt.time_ms      = time_r;
              req_nxt.raw_word     = asm_nxt;
              req_nxt.last         = (scnt_r + 16'd1) == spt_r;
              req_nxt.status       = 1'b0;
              req_nxt.is_ibm       = (fmt_r == FC_IBM);
            end
            time_nxt = time_r + {{14{ivl_r[6]}}, ivl_r};
            scnt_nxt = scnt_r + 16'd1;
            if ((scnt_r + 16'd1) >= spt_r) begin
              phase_nxt = match_r ? PH_DONE : PH_THDR;
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_acc) begin
      v_nxt = emit || (v_r && !req_ready);
    end else begin
      v_nxt = v_r && !req_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      cnt_r   <= 12'd0;
      v_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      v_r     <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    big_r   <= big_nxt;
    spt_r   <= spt_nxt;
    ivl_r   <= ivl_nxt;
    fmt_r   <= fmt_nxt;
    asm_r   <= asm_nxt;
    xl_r    <= xl_nxt;
    il_r    <= il_nxt;
    scnt_r  <= scnt_nxt;
    time_r  <= time_nxt;
    match_r <= match_nxt;
    if (emit) begin
      req_r <= req_nxt;
    end
  end

`ifndef SYNTH
  a_req_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r) |-> $past(in_acc))
    else $error("request appeared without an accepted byte");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (!req_r.status || req_r.last))
    else $error("format error request not marked last");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && req_nxt.last) |=> (phase_r == PH_DONE))
    else $error("parser did not stop after last sample");
`endif

endmodule

>>> design/segy_ibm_cvt.sv
// ----------------------------------------------------------------------------
// segy_ibm_cvt
// IBM hex float to IEEE single conversion with full normalization,
// overflow to infinity and underflow flushed to signed zero; words not
// marked IBM pass through unchanged. Holds the output register.
// ----------------------------------------------------------------------------
module segy_ibm_cvt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_ready,
  input  segy_pkg::req_t req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [14:0]    out_index,
  output logic [20:0]    out_time,
  output logic [31:0]    out_word,
  output logic           out_last,
  output logic           out_status
);

  localparam logic signed [10:0] EXP_BIAS = 11'sd130;
  localparam logic signed [10:0] EXP_MAX  = 11'sd255;
  localparam logic [31:0]        INF_BITS = 32'h7f800000;

  logic           v_r;
  logic           ibm_r;
  logic [14:0]    idx_r;
  logic [20:0]    time_r;
  logic [31:0]    word_r, word_nxt;
  logic           last_r;
  logic           stat_r;
  logic           load;

  logic           sgn;
  logic [6:0]     ex;
  logic [23:0]    frac;
  logic [23:0]    frac_n;
  logic [4:0]     lz;
  logic           found;
  logic signed [10:0] be;

  assign req_ready = !v_r || out_ready;
  assign load      = req_valid && req_ready;

  assign sgn  = req.raw_word[31];
  assign ex   = req.raw_word[30:24];
  assign frac = req.raw_word[23:0];

  always_comb begin
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && frac[i]) begin
        lz    = 5'(23 - i);
        found = 1'b1;
      end
    end
  end

  assign frac_n = frac << lz;
  assign be     = $signed({2'b00, ex, 2'b00}) - EXP_BIAS - $signed({6'd0, lz});

  always_comb begin
    if (!req.is_ibm) begin
      word_nxt = req.raw_word;
    end else if (frac == 24'd0 || be <= 11'sd0) begin
      word_nxt = {sgn, 31'd0};
    end else if (be >= EXP_MAX) begin
      word_nxt = {sgn, 31'd0} | INF_BITS;
    end else begin
      word_nxt = {sgn, be[7:0], frac_n[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (req_ready) begin
      v_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ibm_r  <= req.is_ibm;
      idx_r  <= req.sample_index;
      time_r <= req.time_ms;
      word_r <= word_nxt;
      last_r <= req.last;
      stat_r <= req.status;
    end
  end

  assign out_valid  = v_r;
  assign out_index  = idx_r;
  assign out_time   = time_r;
  assign out_word   = word_r;
  assign out_last   = last_r;
  assign out_status = stat_r;

`ifndef SYNTH
  a_no_denorm: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && ibm_r) |-> (word_r[30:23] != 8'd0 || word_r[22:0] == 23'd0))
    else $error("IBM conversion produced a denormal");
`endif

endmodule

>>> design/segy_trace_select_ibm_to_ieee.sv
// ----------------------------------------------------------------------------
// segy_trace_select_ibm_to_ieee
// SEG-Y byte stream trace picker; emits the samples of the matching trace
// as IEEE single words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained; set by the byte-serial parser.
//   in_tready drops only while both stages hold a sample out_tready refuses.
// Pipeline: two register stages (parser request, converter output); a sample
//   is registered once its last byte is taken, then moves to the converter.
// Reset (rst_n low, synchronous): parse restarts at the text header, both
//   target registers clear to zero, and no request is pending.
module segy_trace_select_ibm_to_ieee (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [14:0] sample_index, [35:15] time_ms,
                                  // [67:36] sample_word, [71:68] zero
  output logic        out_tlast,  // last_sample
  output logic        out_tuser,  // [0] status
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]    tgt_xline_r;
  logic [31:0]    tgt_inline_r;
  logic           req_valid;
  logic           req_ready;
  segy_pkg::req_t req;
  logic [14:0]    o_index;
  logic [20:0]    o_time;
  logic [31:0]    o_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_xline_r  <= 32'd0;
      tgt_inline_r <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        segy_pkg::CFG_TGT_XLINE:  tgt_xline_r  <= cfg_wdata;
        segy_pkg::CFG_TGT_INLINE: tgt_inline_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  segy_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_sof     (in_tuser),
    .tgt_xline  (tgt_xline_r),
    .tgt_inline (tgt_inline_r),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req)
  );

  segy_ibm_cvt u_cvt (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_index  (o_index),
    .out_time   (o_time),
    .out_word   (o_word),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

  assign out_tdata = {4'd0, o_word, o_time, o_index};

endmodule

>>> tb/tb_segy_trace_select_ibm_to_ieee.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segy_trace_select_ibm_to_ieee
// Feeds SEG-Y byte streams (text header, binary header, traces), some cut short,
// in both byte orders and all format codes, retargets the trace between files,
// and scores every emitted sample against an in-bench parser and IBM float
// converter. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb_segy_trace_select_ibm_to_ieee;

  localparam logic REG_CROSSLINE = segy_pkg::CFG_TGT_XLINE;
  localparam logic REG_INLINE    = segy_pkg::CFG_TGT_INLINE;

  localparam logic [15:0] CODE_IBM  = segy_pkg::FMT_CODE_IBM;
  localparam logic [15:0] CODE_INT4 = segy_pkg::FMT_CODE_INT4;
  localparam logic [15:0] CODE_INT2 = segy_pkg::FMT_CODE_INT2;
  localparam logic [15:0] CODE_FIX4 = segy_pkg::FMT_CODE_FIX4;
  localparam logic [15:0] CODE_IEEE = segy_pkg::FMT_CODE_IEEE;

  typedef enum logic [2:0] {HDR_TEXT, HDR_BIN, TRC_HDR, TRC_DATA, STOPPED} parse_e;
  typedef enum logic [2:0] {FMT_IBM, FMT_IEEE, FMT_BAD4, FMT_BAD2, FMT_NONE} fmt_e;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_MOSTLY, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic [segy_pkg::IDX_W-1:0]  idx;
    logic [segy_pkg::TIME_W-1:0] tms;
    logic [segy_pkg::WORD_W-1:0] word;
    logic                        last;
    logic                        status;
  } sample_t;

  typedef struct {
    bit          msb;
    logic [15:0] fmt;
    logic [15:0] ns;
    logic [15:0] dt;
    int          n_traces;
    int          hit;
    logic [31:0] xl;
    logic [31:0] il;
    int          tail;
  } file_plan_t;

  class sample_scoreboard;
    sample_t     pending_samples[$];
    int          n_bad;
    logic [31:0] tgt_xl, tgt_il;
    parse_e      phase;
    int unsigned bcnt;
    bit          msb_first;
    logic [15:0] nsamp;
    int          interval;
    fmt_e        fclass;
    logic [31:0] shreg;
    logic [31:0] cur_xl, cur_il;
    int unsigned scnt;
    int          tacc;
    bit          on_target;
    bit          stopped;

    function new();
      n_bad = 0;
      tgt_xl = '0;
      tgt_il = '0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = HDR_TEXT;
      bcnt = 0;
      msb_first = 1'b0;
      nsamp = '0;
      interval = 0;
      fclass = FMT_IBM;
      shreg = '0;
      cur_xl = '0;
      cur_il = '0;
      scnt = 0;
      tacc = 0;
      on_target = 1'b0;
      stopped = 1'b0;
    endfunction

    function void set_target(logic idx, logic [31:0] v);
      if (idx == REG_CROSSLINE) tgt_xl = v;
      else tgt_il = v;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function void note_failure(string msg);
      if (n_bad < 10) $display("%s", msg);
      n_bad++;
    endfunction

    function logic [31:0] shift_in(logic [31:0] acc, logic [7:0] b);
      if (msb_first) return {acc[23:0], b};
      return {b, acc[31:8]};
    endfunction

    function int unsigned sample_bytes();
      if (fclass == FMT_BAD2) return 2;
      if (fclass == FMT_NONE) return 0;
      return 4;
    endfunction

    function logic [31:0] ibm_to_single(logic [31:0] w);
      logic [23:0] f;
      int          k;
      int          bexp;
      f = w[23:0];
      k = 0;
      if (f == '0) return {w[31], 31'b0};
      while (!f[23]) begin
        f = f << 1;
        k++;
      end
      bexp = 4 * int'(w[30:24]) - 130 - k;
      if (bexp >= 255) return {w[31], 8'hFF, 23'b0};
      if (bexp <= 0) return {w[31], 31'b0};
      return {w[31], bexp[7:0], f[22:0]};
    endfunction

    function void decode_header(logic [7:0] hi);
      logic [7:0] lo;
      shortint    raw, code, dt, ns;
      lo = shreg[23:16];
      raw = shortint'({hi, lo});
      msb_first = !(raw >= 1 && raw <= 5);
      if (msb_first) begin
        code = shortint'({lo, hi});
        dt = shortint'({shreg[7:0], shreg[15:8]});
        ns = shortint'({nsamp[7:0], nsamp[15:8]});
      end else begin
        code = raw;
        dt = shortint'(shreg[15:0]);
        ns = shortint'(nsamp);
      end
      interval = dt / 1000;
      nsamp = (ns > 0) ? ns : 16'd0;
      case (code)
        CODE_IBM:             fclass = FMT_IBM;
        CODE_IEEE:            fclass = FMT_IEEE;
        CODE_INT4, CODE_FIX4: fclass = FMT_BAD4;
        CODE_INT2:            fclass = FMT_BAD2;
        default:              fclass = FMT_NONE;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      int unsigned pos;
      sample_t     s;
      if (sof) clear_parse();
      if (stopped) return;
      pos = bcnt;
      case (phase)
        HDR_TEXT: begin
          if (pos >= 3199) begin
            phase = HDR_BIN;
            bcnt = 0;
          end else bcnt = pos + 1;
        end
        HDR_BIN: begin
          case (pos)
            16: shreg[7:0] = b;
            17: shreg[15:8] = b;
            20: nsamp[7:0] = b;
            21: nsamp[15:8] = b;
            24: shreg[23:16] = b;
            25: decode_header(b);
            default: ;
          endcase
          if (pos >= 399) begin
            phase = TRC_HDR;
            bcnt = 0;
          end else bcnt = pos + 1;
        end
        TRC_HDR: begin
          if (pos >= 8 && pos <= 11) cur_xl = shift_in(cur_xl, b);
          else if (pos >= 12 && pos <= 15) cur_il = shift_in(cur_il, b);
          if (pos < 239) bcnt = pos + 1;
          else begin
            bcnt = 0;
            scnt = 0;
            tacc = 0;
            on_target = (cur_xl == tgt_xl) && (cur_il == tgt_il);
            if (on_target && nsamp != 0 && fclass != FMT_IBM && fclass != FMT_IEEE) begin
              s.idx = '0;
              s.tms = '0;
              s.word = '0;
              s.last = 1'b1;
              s.status = 1'b1;
              pending_samples.push_back(s);
              phase = STOPPED;
              stopped = 1'b1;
            end else if (nsamp == 0 || sample_bytes() == 0) begin
              if (on_target) begin
                phase = STOPPED;
                stopped = 1'b1;
              end
            end else phase = TRC_DATA;
          end
        end
        TRC_DATA: begin
          shreg = shift_in(shreg, b);
          if (pos + 1 < sample_bytes()) bcnt = pos + 1;
          else begin
            bcnt = 0;
            if (on_target) begin
              s.idx = scnt[segy_pkg::IDX_W-1:0];
              s.tms = tacc[segy_pkg::TIME_W-1:0];
              s.word = (fclass == FMT_IBM) ? ibm_to_single(shreg) : shreg;
              s.last = (scnt + 1 == nsamp);
              s.status = 1'b0;
              pending_samples.push_back(s);
            end
            tacc += interval;
            scnt++;
            if (scnt >= nsamp) begin
              if (on_target) begin
                phase = STOPPED;
                stopped = 1'b1;
              end else phase = TRC_HDR;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      string   bad;
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("unexpected sample: idx=%0d t=%0d w=%h last=%0b st=%0b",
                               got.idx, $signed(got.tms), got.word, got.last, got.status));
        return;
      end
      want = pending_samples.pop_front();
      bad = "";
      if (got.idx != want.idx) bad = {bad, " sample_index"};
      if (got.tms != want.tms) bad = {bad, " time_ms"};
      if (got.word != want.word) bad = {bad, " sample_word"};
      if (got.last != want.last) bad = {bad, " last_sample"};
      if (got.status != want.status) bad = {bad, " status"};
      if (bad != "")
        note_failure({
          $sformatf("mismatch in%s: expected idx=%0d t=%0d w=%h last=%0b st=%0b,",
                    bad, want.idx, $signed(want.tms), want.word, want.last,
                    want.status),
          $sformatf(" got idx=%0d t=%0d w=%h last=%0b st=%0b",
                    got.idx, $signed(got.tms), got.word, got.last, got.status)});
    endfunction

    function void flush_leftover();
      if (pending_samples.size() != 0)
        note_failure($sformatf("%0d expected samples never arrived", pending_samples.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [31:0] cfg_wdata = '0;

  sample_scoreboard sb;
  sample_t          seen;
  logic [7:0]       file_q[$];
  logic [31:0]      word_pool[$];
  logic [31:0]      tgt_xl = '0;
  logic [31:0]      tgt_il = '0;
  bit               gaps_on = 1'b1;
  int               burst_left = 0;
  rx_mode_e         rx_mode = RX_FREE;
  logic [7:0]       rx_tick = '0;
  int               rx_hold = 0;

  segy_trace_select_ibm_to_ieee u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: mode changes each time the 8-bit rx_tick counter wraps to zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_hold != 0) begin
          out_tready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          out_tready <= 1'b0;
          rx_hold <= $urandom_range(1, 40);
        end else out_tready <= 1'b1;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.idx = out_tdata[14:0];
        seen.tms = out_tdata[35:15];
        seen.word = out_tdata[67:36];
        seen.last = out_tlast;
        seen.status = out_tuser;
        sb.check_sample(seen);
      end
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic sof);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= sof;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off until every expected sample is out, then let the pipe settle
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic retarget(input logic [31:0] xl, input logic [31:0] il);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_CROSSLINE;
    cfg_wdata <= xl;
    @(posedge clk);
    sb.set_target(REG_CROSSLINE, xl);
    cfg_addr <= REG_INLINE;
    cfg_wdata <= il;
    @(posedge clk);
    sb.set_target(REG_INLINE, il);
    cfg_wr_en <= 1'b0;
    tgt_xl = xl;
    tgt_il = il;
  endtask

  function automatic void put_field(int at, logic [31:0] v, int nbytes, bit msb);
    for (int i = 0; i < nbytes; i++)
      file_q[at + i] = msb ? v[8 * (nbytes - 1 - i) +: 8] : v[8 * i +: 8];
  endfunction

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic file_plan_t base_plan(bit msb, logic [15:0] fmt, logic [15:0] ns,
                                           logic [15:0] dt, int n_traces, int hit);
    file_plan_t p;
    p.msb = msb;
    p.fmt = fmt;
    p.ns = ns;
    p.dt = dt;
    p.n_traces = n_traces;
    p.hit = hit;
    p.xl = tgt_xl;
    p.il = tgt_il;
    p.tail = $urandom_range(0, 200);
    return p;
  endfunction

  function automatic void build_file(file_plan_t p);
    int          base;
    int          bps;
    int          n_samp;
    logic [31:0] xl, il, w;
    file_q.delete();
    repeat (3600) file_q.push_back(8'($urandom));
    put_field(3200 + 16, {16'h0, p.dt}, 2, p.msb);
    put_field(3200 + 20, {16'h0, p.ns}, 2, p.msb);
    put_field(3200 + 24, {16'h0, p.fmt}, 2, p.msb);
    case (p.fmt)
      CODE_IBM, CODE_IEEE, CODE_INT4, CODE_FIX4: bps = 4;
      CODE_INT2:                                 bps = 2;
      default:                                   bps = 0;
    endcase
    n_samp = (shortint'(p.ns) > 0) ? int'(p.ns) : 0;
    for (int t = 0; t < p.n_traces; t++) begin
      base = file_q.size();
      repeat (240) file_q.push_back(8'($urandom));
      if (t == p.hit) begin
        xl = p.xl;
        il = p.il;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            xl = p.xl;
            il = p.il ^ (32'h1 << $urandom_range(0, 31));
          end
          1: begin
            xl = p.xl ^ (32'h1 << $urandom_range(0, 31));
            il = p.il;
          end
          default: begin
            xl = $urandom;
            il = $urandom;
          end
        endcase
      end
      put_field(base + 8, xl, 4, p.msb);
      put_field(base + 12, il, 4, p.msb);
      for (int s = 0; s < n_samp && bps != 0; s++) begin
        if (word_pool.size() != 0) w = word_pool.pop_front();
        else begin
          case ($urandom_range(0, 7))
            0:       w = {1'($urandom), 7'($urandom), 24'h0};
            1:       w = {1'($urandom), 7'h7F, 24'($urandom) | 24'h1};
            2:       w = {1'($urandom), 7'($urandom_range(0, 33)), 24'($urandom)};
            3:       w = {1'($urandom), 7'($urandom), 24'h1 << $urandom_range(0, 23)};
            default: w = $urandom;
          endcase
        end
        base = file_q.size();
        repeat (bps) file_q.push_back(8'h00);
        put_field(base, w, bps, p.msb);
      end
    end
    repeat (p.tail) file_q.push_back(8'($urandom));
  endfunction

  task automatic run_file(input file_plan_t p, input bit with_sof, input bit cut);
    int keep;
    build_file(p);
    if (cut) begin
      keep = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    foreach (file_q[i]) push_byte(file_q[i], with_sof && (i == 0));
  endtask

  initial begin
    file_plan_t  p;
    logic [15:0] fmt, ns, dt;
    bit          msb;
    int          n_tr;
    int          nfile;
    int          n_done;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // IBM edge cases against reset targets: signed zeros, overflow,
    // underflow flush, denormal fractions, largest normal
    word_pool = '{32'h0000_0000, 32'h8000_0000, 32'hC500_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h2080_0000, 32'h2180_0000,
                  32'h4100_0001, 32'h6080_0000, 32'h6180_0000, 32'hC210_0000};
    run_file(base_plan(1'b0, CODE_IBM, 16'd12, 16'd1000, 2, 0), 1'b1, 1'b0);
    retarget(32'h8000_0000, 32'h7FFF_FFFF);
    run_file(base_plan(1'b1, CODE_IEEE, 16'd3, 16'h8000, 3, 2), 1'b1, 1'b0);
    retarget(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_file(base_plan(1'b1, CODE_INT4, 16'd2, 16'd999, 2, 1), 1'b1, 1'b0);
    retarget(32'h7FFF_FFFF, 32'h8000_0000);
    run_file(base_plan(1'b0, CODE_INT2, 16'd5, 16'd2000, 2, 1), 1'b1, 1'b0);
    retarget($urandom, $urandom);
    run_file(base_plan(1'b1, 16'd0, 16'd3, 16'h7FFF, 2, 1), 1'b1, 1'b0);
    run_file(base_plan(1'b0, CODE_IBM, 16'hFFF0, 16'd4000, 3, 1), 1'b1, 1'b0);
    run_file(base_plan(1'b1, CODE_FIX4, 16'd0, 16'd1000, 2, 0), 1'b1, 1'b0);
    // stopped: a stream without a start marker is ignored
    run_file(base_plan(1'b0, CODE_IEEE, 16'd4, 16'd1000, 2, 0), 1'b0, 1'b0);
    run_file(base_plan(1'b0, CODE_IEEE, 16'd4, 16'd3000, 3, -1), 1'b1, 1'b0);
    run_file(base_plan(1'b0, CODE_IEEE, 16'd6, 16'hFC18, 2, 0), 1'b1, 1'b1);
    retarget($urandom, $urandom);
    gaps_on = 1'b0;
    run_file(base_plan(1'b0, CODE_IBM, 16'h7FFF, 16'h7FFF, 1, 0), 1'b1, 1'b0);
    gaps_on = 1'b1;

    nfile = 0;
    n_done = 0;
    while (nfile < 24 || (sb.n_bad == 0 && n_done < 60 && nfile < 60)) begin
      retarget(rand_target(), rand_target());
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(20, 400))
          push_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      msb = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: fmt = $urandom_range(0, 1) ? CODE_IBM : CODE_IEEE;
        7: fmt = $urandom_range(0, 1) ? CODE_INT4 : CODE_FIX4;
        8: fmt = CODE_INT2;
        default: begin
          case ($urandom_range(0, 3))
            0:       fmt = 16'd0;
            1:       fmt = 16'd6;
            2:       fmt = 16'hFFFF;
            default: fmt = 16'($urandom);
          endcase
          msb = 1'b1;
        end
      endcase
      case ($urandom_range(0, 9))
        8:       ns = $urandom_range(0, 1) ? 16'd0 : (16'h8000 | 16'($urandom));
        9:       ns = 16'($urandom_range(13, 64));
        default: ns = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       dt = 16'd0;
        1:       dt = 16'h7FFF;
        2:       dt = 16'h8000;
        3:       dt = 16'($urandom_range(0, 999));
        default: dt = 16'($urandom);
      endcase
      n_tr = $urandom_range(1, 6);
      p = base_plan(msb, fmt, ns, dt, n_tr,
                    ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, n_tr - 1));
      if (p.hit >= 0 && shortint'(ns) > 0 && (fmt == CODE_IBM || fmt == CODE_IEEE))
        n_done += int'(ns);
      run_file(p, ($urandom_range(0, 15) != 0), ($urandom_range(0, 7) == 0));
      nfile++;
    end

    wait_quiet();
    sb.flush_leftover();
    if (sb.n_bad == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> segy_trace_select_ibm_to_ieee.f
design/segy_pkg.sv
design/segy_parse.sv
design/segy_ibm_cvt.sv
design/segy_trace_select_ibm_to_ieee.sv
tb/tb_segy_trace_select_ibm_to_ieee.sv
